### rtl/owbm_pkg.sv
// Package for the one-wire bus master: payload structs, phase and request
// codes, configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package owbm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BitCntW       = $clog2(BITS_PER_BYTE + 1);
  localparam int unsigned TimeW         = 10;
  localparam int unsigned NumCfg        = 8;
  localparam int unsigned CfgIdxW       = $clog2(NumCfg);

  // fixed released time after a read sample
  localparam logic [TimeW-1:0] ReadTailTime = 10'd55;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_TAIL  = 4'd3,
    PH_SLOT_LOW  = 4'd4,
    PH_READ_WAIT = 4'd5,
    PH_SLOT_TAIL = 4'd6
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_SHORT_LOW     = 3'd3,
    CFG_WRITE_ONE_TL  = 3'd4,
    CFG_WRITE_ZERO_LO = 3'd5,
    CFG_WRITE_ZERO_TL = 3'd6,
    CFG_READ_SAMPLE   = 3'd7
  } cfg_idx_e;

  typedef logic [NumCfg-1:0][TimeW-1:0] cfg_regs_t;

  // register 7 down to register 0
  localparam cfg_regs_t CfgReset = {10'd9, 10'd10, 10'd60, 10'd64,
                                    10'd6, 10'd410, 10'd70, 10'd480};

  typedef struct packed {
    req_e       req_type;
    logic [7:0] tx_byte;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic       bus_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_level;
    logic [7:0] read_byte;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/owbm_seq.sv
// Bus sequencer: phase state machine, interval counter, bit counter and
// shift register. Depends on owbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module owbm_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire owbm_pkg::in_item_t item_i,
  input  wire owbm_pkg::cfg_regs_t cfg_i,
  output owbm_pkg::out_item_t     result_o
);

  owbm_pkg::phase_e                  phase_q, phase_d;
  owbm_pkg::req_e                    op_q, op_d;
  logic [owbm_pkg::TimeW-1:0]        time_left_q, time_left_d;
  logic [owbm_pkg::BitCntW-1:0]      bit_count_q, bit_count_d;
  logic [owbm_pkg::BitCntW-1:0]      bit_count_inc;
  logic [7:0]                        shift_q, shift_d;
  logic                              presence_q, presence_d;
  logic                              done;
  logic [owbm_pkg::TimeW-1:0]        slot_low_time;

  assign bit_count_inc = bit_count_q + 1'b1;

  // Next state
  always_comb begin
    phase_d     = phase_q;
    op_d        = op_q;
    time_left_d = time_left_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    presence_d  = presence_q;
    done        = 1'b0;
    if (item_i.req_type == owbm_pkg::REQ_TICK) begin
      if (phase_q != owbm_pkg::PH_IDLE) begin
        if (time_left_q > 10'd1) begin
          time_left_d = time_left_q - 1'b1;
        end else begin
          unique case (phase_q)
            owbm_pkg::PH_RST_LOW: begin
              phase_d     = owbm_pkg::PH_RST_WAIT;
              time_left_d = cfg_i[owbm_pkg::CFG_PRESENCE_WAIT];
            end
            owbm_pkg::PH_RST_WAIT: begin
              presence_d  = item_i.bus_level;
              phase_d     = owbm_pkg::PH_RST_TAIL;
              time_left_d = cfg_i[owbm_pkg::CFG_RESET_TAIL];
            end
            owbm_pkg::PH_RST_TAIL: begin
              phase_d     = owbm_pkg::PH_IDLE;
              time_left_d = '0;
              done        = 1'b1;
            end
            owbm_pkg::PH_SLOT_LOW: begin
              if (op_q == owbm_pkg::REQ_READ) begin
                phase_d     = owbm_pkg::PH_READ_WAIT;
                time_left_d = cfg_i[owbm_pkg::CFG_READ_SAMPLE];
              end else begin
                phase_d     = owbm_pkg::PH_SLOT_TAIL;
                time_left_d = shift_q[0] ? cfg_i[owbm_pkg::CFG_WRITE_ONE_TL]
                                         : cfg_i[owbm_pkg::CFG_WRITE_ZERO_TL];
              end
            end
            owbm_pkg::PH_READ_WAIT: begin
              shift_d     = {item_i.bus_level, shift_q[7:1]};
              phase_d     = owbm_pkg::PH_SLOT_TAIL;
              time_left_d = owbm_pkg::ReadTailTime;
            end
            owbm_pkg::PH_SLOT_TAIL: begin
              if (op_q == owbm_pkg::REQ_WRITE) shift_d = {1'b0, shift_q[7:1]};
              bit_count_d = bit_count_inc;
              if (bit_count_inc >= owbm_pkg::BitCntW'(owbm_pkg::BITS_PER_BYTE)) begin
                phase_d     = owbm_pkg::PH_IDLE;
                time_left_d = '0;
                done        = 1'b1;
              end else begin
                phase_d     = owbm_pkg::PH_SLOT_LOW;
                time_left_d = slot_low_time;
              end
            end
            default: begin
              phase_d     = owbm_pkg::PH_IDLE;
              time_left_d = '0;
            end
          endcase
        end
      end
    end else if (phase_q == owbm_pkg::PH_IDLE) begin
      // start a command; a command while busy is dropped
      op_d        = item_i.req_type;
      bit_count_d = '0;
      if (item_i.req_type == owbm_pkg::REQ_RESET) begin
        phase_d     = owbm_pkg::PH_RST_LOW;
        time_left_d = cfg_i[owbm_pkg::CFG_RESET_LOW];
      end else begin
        shift_d     = (item_i.req_type == owbm_pkg::REQ_WRITE) ? item_i.tx_byte : 8'h00;
        phase_d     = owbm_pkg::PH_SLOT_LOW;
        time_left_d = slot_low_time;
      end
    end
  end

  // Low time of a new slot follows the operation and bit being sent
  always_comb begin
    if (op_d == owbm_pkg::REQ_WRITE && !shift_d[0]) begin
      slot_low_time = cfg_i[owbm_pkg::CFG_WRITE_ZERO_LO];
    end else begin
      slot_low_time = cfg_i[owbm_pkg::CFG_SHORT_LOW];
    end
  end

  // Outputs, from the state after this transfer
  always_comb begin
    result_o.bus_drive_low  = (phase_d == owbm_pkg::PH_RST_LOW) ||
                              (phase_d == owbm_pkg::PH_SLOT_LOW);
    result_o.busy_res       = (phase_d != owbm_pkg::PH_IDLE);
    result_o.done_res       = done;
    result_o.presence_level = presence_d;
    result_o.read_byte      = (op_d == owbm_pkg::REQ_READ) ? shift_d : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= owbm_pkg::PH_IDLE;
      op_q        <= owbm_pkg::REQ_TICK;
      time_left_q <= '0;
      bit_count_q <= '0;
      shift_q     <= '0;
      presence_q  <= 1'b1;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      op_q        <= op_d;
      time_left_q <= time_left_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      presence_q  <= presence_d;
    end
  end

endmodule
`default_nettype wire

### rtl/one_wire_bus_master_unit.sv
// Top level of the one-wire bus master: configuration registers, handshake
// and result register. Depends on owbm_pkg and owbm_seq.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One transfer per cycle: each item updates the sequencer state in the cycle
// it is taken, and its result sits in the output register the next cycle.
// The input is taken whenever that register is empty or being drained.
// Reset clears the sequencer to idle and loads the default timings.
// A stalled output holds its result and stops further input transfers.
`timescale 1ns / 1ps
`default_nettype none
module one_wire_bus_master_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire owbm_pkg::in_item_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output owbm_pkg::out_item_t                 out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [owbm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [owbm_pkg::TimeW-1:0]     cfg_data_i
);

  owbm_pkg::cfg_regs_t cfg_q;
  owbm_pkg::out_item_t result;
  owbm_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= owbm_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  owbm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= result;
  end

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done result still shows busy");

  a_drive_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bus_drive_low |-> out_q.busy_res)
    else $error("bus driven low while idle");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item left no result");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule
`default_nettype wire
